>>> rtl/filtered_speed_pi_loop_top_macros.svh
// Assertion helpers for the speed PI loop.
`ifndef FILTERED_SPEED_PI_LOOP_TOP_MACROS_SVH
`define FILTERED_SPEED_PI_LOOP_TOP_MACROS_SVH

// Same-cycle implication.
`define FSPL_ASSERT_IMPL(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication.
`define FSPL_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

>>> rtl/fspl_pkg.sv
package fspl_pkg;

   localparam int FILT_BITS      = 26;
   localparam int INTEG_BITS     = 23;
   localparam int COUNT_BITS     = 16;
   localparam int GAIN_BITS      = 16;
   localparam int DRIVE_BITS     = 16;
   localparam int DIV_BITS       = 2;
   localparam int CSR_INDEX_BITS = 2;
   localparam int CSR_DATA_BITS  = 16;

   localparam int INTEGRAL_LIMIT_DEF = 10000;
   localparam int FRACTION_BITS_DEF  = 8;

   localparam int TARGET_FAST    = 110;
   localparam int TARGET_SLOW    = 55;
   localparam int FILTER_DIVISOR = 5;

   localparam logic [GAIN_BITS-1:0] PROP_GAIN_RST  = 16'd30720;
   localparam logic [GAIN_BITS-1:0] INTEG_GAIN_RST = 16'd102;
   localparam logic [DIV_BITS-1:0]  SPEED_DIV_RST  = 2'd2;

   typedef enum logic [CSR_INDEX_BITS-1:0] {
      REG_PROP_GAIN,
      REG_INTEG_GAIN,
      REG_AVOID_MODE,
      REG_SPEED_DIVISOR
   } csr_reg_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DIVIDE,
      ST_INTEG,
      ST_LAUNCH,
      ST_MAC
   } fsm_state_type;

   typedef struct packed {
      logic busy;
      logic done;
   } unit_stat_type;

   // Width of the filter dividend 4*filt + (sum << frac), signed.
   function automatic int dividend_bits(int frac);
      int a;
      int b;
      a = FILT_BITS + 2;
      b = COUNT_BITS + 1 + frac;
      return ((a > b) ? a : b) + 1;
   endfunction

endpackage

>>> rtl/fspl_div5.sv
module fspl_div5 #(
   parameter int FRACTION_BITS = fspl_pkg::FRACTION_BITS_DEF
) (
   input  logic                                                clock,
   input  logic                                                reset,
   input  logic                                                start,
   input  logic [fspl_pkg::dividend_bits(FRACTION_BITS)-1:0]  dividend,
   output logic [fspl_pkg::dividend_bits(FRACTION_BITS)-1:0]  quotient,
   output fspl_pkg::unit_stat_type                             stat
);
   import fspl_pkg::*;

   localparam int XW       = dividend_bits(FRACTION_BITS);
   localparam int REM_BITS = $clog2(FILTER_DIVISOR);
   localparam int CNT_BITS = $clog2(XW + 1);

   logic [XW-1:0]       num_ff, num_in;
   logic [REM_BITS-1:0] rem_ff, rem_in;
   logic [CNT_BITS-1:0] cnt_ff, cnt_in;
   logic                done_ff, done_in;
   logic [REM_BITS:0]   trial;
   logic                ge;

   // Restoring long division, one quotient bit per cycle, MSB first.
   // Quotient bits shift into the low end as dividend bits leave the top.
   always_comb begin
      trial   = {rem_ff, num_ff[XW-1]};
      ge      = (trial >= (REM_BITS+1)'(FILTER_DIVISOR));
      num_in  = num_ff;
      rem_in  = rem_ff;
      cnt_in  = cnt_ff;
      done_in = done_ff;
      if (start) begin
         num_in  = dividend;
         rem_in  = '0;
         cnt_in  = CNT_BITS'(XW);
         done_in = 1'b0;
      end else if (cnt_ff != '0) begin
         num_in  = {num_ff[XW-2:0], ge};
         rem_in  = ge ? REM_BITS'(trial - (REM_BITS+1)'(FILTER_DIVISOR))
                      : trial[REM_BITS-1:0];
         cnt_in  = cnt_ff - CNT_BITS'(1);
         done_in = (cnt_ff == CNT_BITS'(1));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff  <= '0;
         done_ff <= 1'b0;
      end else begin
         cnt_ff  <= cnt_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      num_ff <= num_in;
      rem_ff <= rem_in;
   end

   assign quotient  = num_ff;
   assign stat.busy = (cnt_ff != '0);
   assign stat.done = done_ff;

endmodule

>>> rtl/fspl_mac.sv
module fspl_mac #(
   parameter int FRACTION_BITS = fspl_pkg::FRACTION_BITS_DEF
) (
   input  logic                                     clock,
   input  logic                                     reset,
   input  logic                                     start,
   input  logic signed [fspl_pkg::FILT_BITS-1:0]    filt,
   input  logic signed [fspl_pkg::INTEG_BITS-1:0]   integ,
   input  logic        [fspl_pkg::GAIN_BITS-1:0]    prop_gain,
   input  logic        [fspl_pkg::GAIN_BITS-1:0]    integ_gain,
   output fspl_pkg::unit_stat_type                  stat,
   output logic signed [fspl_pkg::DRIVE_BITS-1:0]   drive
);
   import fspl_pkg::*;

   localparam int AW       = FILT_BITS + GAIN_BITS + 1;
   localparam int SH       = 2 * FRACTION_BITS;
   localparam int CNT_BITS = $clog2(GAIN_BITS + 1);
   localparam logic signed [AW-1:0] DRV_MAX = AW'((1 <<< (DRIVE_BITS - 1)) - 1);
   localparam logic signed [AW-1:0] DRV_MIN = -DRV_MAX - AW'(1);

   logic signed [FILT_BITS-1:0]  fop_ff, fop_in;
   logic signed [INTEG_BITS-1:0] iop_ff, iop_in;
   logic signed [FILT_BITS:0]    both_ff, both_in;
   logic [GAIN_BITS-1:0]         kp_ff, kp_in;
   logic [GAIN_BITS-1:0]         ki_ff, ki_in;
   logic signed [AW-1:0]         acc_ff, acc_in;
   logic [CNT_BITS-1:0]          cnt_ff, cnt_in;
   logic                         fin_ff, fin_in;
   logic                         done_ff, done_in;
   logic signed [DRIVE_BITS-1:0] drive_ff, drive_in;

   logic signed [AW-1:0] addend;
   logic signed [AW-1:0] shifted;
   logic signed [AW-1:0] trunc;
   logic                 round_up;

   // Gain bits select the addend; filt+integ is precomputed for 11.
   always_comb begin
      case ({kp_ff[GAIN_BITS-1], ki_ff[GAIN_BITS-1]})
         2'b10:   addend = AW'(fop_ff);
         2'b01:   addend = AW'(iop_ff);
         2'b11:   addend = AW'(both_ff);
         default: addend = '0;
      endcase
   end

   // Divide by 2^(2F) toward zero: negative with dropped bits rounds up.
   always_comb begin
      shifted  = acc_ff >>> SH;
      round_up = acc_ff[AW-1] & (|acc_ff[SH-1:0]);
      trunc    = shifted + (round_up ? AW'(1) : AW'(0));
   end

   always_comb begin
      fop_in   = fop_ff;
      iop_in   = iop_ff;
      both_in  = both_ff;
      kp_in    = kp_ff;
      ki_in    = ki_ff;
      acc_in   = acc_ff;
      cnt_in   = cnt_ff;
      fin_in   = fin_ff;
      done_in  = done_ff;
      drive_in = drive_ff;
      if (start) begin
         fop_in  = filt;
         iop_in  = integ;
         both_in = (FILT_BITS+1)'(filt) + (FILT_BITS+1)'(integ);
         kp_in   = prop_gain;
         ki_in   = integ_gain;
         acc_in  = '0;
         cnt_in  = CNT_BITS'(GAIN_BITS);
         fin_in  = 1'b0;
         done_in = 1'b0;
      end else if (cnt_ff != '0) begin
         // Horner step, gain bits MSB first
         acc_in = (acc_ff <<< 1) + addend;
         kp_in  = kp_ff << 1;
         ki_in  = ki_ff << 1;
         cnt_in = cnt_ff - CNT_BITS'(1);
         fin_in = (cnt_ff == CNT_BITS'(1));
      end else if (fin_ff) begin
         if (trunc > DRV_MAX) begin
            drive_in = DRIVE_BITS'(DRV_MAX);
         end else if (trunc < DRV_MIN) begin
            drive_in = DRIVE_BITS'(DRV_MIN);
         end else begin
            drive_in = DRIVE_BITS'(trunc);
         end
         fin_in  = 1'b0;
         done_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff  <= '0;
         fin_ff  <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         cnt_ff  <= cnt_in;
         fin_ff  <= fin_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      fop_ff   <= fop_in;
      iop_ff   <= iop_in;
      both_ff  <= both_in;
      kp_ff    <= kp_in;
      ki_ff    <= ki_in;
      acc_ff   <= acc_in;
      drive_ff <= drive_in;
   end

   assign stat.busy = (cnt_ff != '0) | fin_ff;
   assign stat.done = done_ff;
   assign drive     = drive_ff;

endmodule

>>> rtl/filtered_speed_pi_loop_top.sv
// Velocity PI loop of a two-wheel balancing robot. One req beat per control
// tick carries both encoder counts and the forward/backward flags; one rsp
// beat returns the drive term. The count sum is low-pass filtered
// (0.8 old + 0.2 new, Q(FRACTION_BITS)), added to an integral that also
// takes the commanded movement and is clamped to +-INTEGRAL_LIMIT, and
// drive = filt*Kp + integ*Ki scaled down by 2^(2F) toward zero, saturated
// to 16 bits. From acceptance, the filter's divide by 5 retires one quotient
// bit per cycle, and then the gain multiply consumes one bit of each 16-bit
// gain per cycle. One beat is in work at a time; the next req beat can be
// taken in the same cycle in which rsp_valid rises. A new req beat is taken
// while the previous result still sits in the rsp register.
// Configuration writes are taken at any time (csr_ready is always high) but
// must only happen while idle.
`include "filtered_speed_pi_loop_top_macros.svh"

module filtered_speed_pi_loop_top #(
   parameter int INTEGRAL_LIMIT = fspl_pkg::INTEGRAL_LIMIT_DEF,
   parameter int FRACTION_BITS  = fspl_pkg::FRACTION_BITS_DEF
) (
   input  logic                                       clock,
   input  logic                                       reset,
   // configuration write channel
   input  logic                                       csr_valid,
   output logic                                       csr_ready,
   input  logic [fspl_pkg::CSR_INDEX_BITS-1:0]        csr_index,
   input  logic [fspl_pkg::CSR_DATA_BITS-1:0]         csr_data,
   // input beats
   input  logic                                       req_valid,
   output logic                                       req_ready,
   input  logic signed [fspl_pkg::COUNT_BITS-1:0]     req_left_count,
   input  logic signed [fspl_pkg::COUNT_BITS-1:0]     req_right_count,
   input  logic                                       req_forward,
   input  logic                                       req_backward,
   // result beats
   output logic                                       rsp_valid,
   input  logic                                       rsp_ready,
   output logic signed [fspl_pkg::DRIVE_BITS-1:0]     rsp_drive
);
   import fspl_pkg::*;

   // ---------------------------------------------------------------------
   // Widths and elaboration-time constants
   // ---------------------------------------------------------------------
   localparam int XW       = dividend_bits(FRACTION_BITS);
   localparam int LIM_BITS = $clog2(INTEGRAL_LIMIT + 1) + FRACTION_BITS + 1;
   localparam int IW       = ((FILT_BITS + 2 > LIM_BITS) ? FILT_BITS + 2 : LIM_BITS) + 1;
   localparam int MW       = $clog2(TARGET_FAST + 1) + FRACTION_BITS + 1;

   // Integral clamp: +-limit intersected with the 23-bit store range.
   localparam logic signed [IW-1:0] LIM_Q =
      IW'(longint'(INTEGRAL_LIMIT) << FRACTION_BITS);
   localparam logic signed [IW-1:0] INTEG_MAX_Q =
      IW'((longint'(1) << (INTEG_BITS - 1)) - 1);
   localparam logic signed [IW-1:0] INTEG_MIN_Q = -INTEG_MAX_Q - IW'(1);
   localparam logic signed [IW-1:0] INTEG_HI = (LIM_Q < INTEG_MAX_Q) ? LIM_Q : INTEG_MAX_Q;
   localparam logic signed [IW-1:0] INTEG_LO = (-LIM_Q > INTEG_MIN_Q) ? -LIM_Q : INTEG_MIN_Q;

   // Movement step magnitudes in Q(F); divisor 3 truncates.
   localparam logic signed [MW-1:0] MOVE_FAST =
      MW'(longint'(TARGET_FAST) << FRACTION_BITS);
   localparam logic signed [MW-1:0] MOVE_SLOW =
      MW'(longint'(TARGET_SLOW) << FRACTION_BITS);
   localparam logic signed [MW-1:0] MOVE_THIRD =
      MW'((longint'(TARGET_FAST) << FRACTION_BITS) / 3);

   // Filter saturation magnitudes.
   localparam logic [XW-1:0] FILT_MAX_MAG = XW'((longint'(1) << (FILT_BITS - 1)) - 1);
   localparam logic [XW-1:0] FILT_MIN_MAG = FILT_MAX_MAG + XW'(1);

   // ---------------------------------------------------------------------
   // Registers
   // ---------------------------------------------------------------------
   logic [GAIN_BITS-1:0]          prop_gain_ff, prop_gain_in;
   logic [GAIN_BITS-1:0]          integ_gain_ff, integ_gain_in;
   logic                          avoid_mode_ff, avoid_mode_in;
   logic [DIV_BITS-1:0]           speed_divisor_ff, speed_divisor_in;

   fsm_state_type                 state_ff, state_in;
   logic signed [FILT_BITS-1:0]   filt_ff, filt_in;
   logic signed [INTEG_BITS-1:0]  integ_ff, integ_in;
   logic signed [MW-1:0]          move_ff, move_in;
   logic                          neg_ff, neg_in;
   logic                          rsp_valid_ff, rsp_valid_in;
   logic signed [DRIVE_BITS-1:0]  rsp_drive_ff, rsp_drive_in;

   // ---------------------------------------------------------------------
   // Combinational
   // ---------------------------------------------------------------------
   logic                          csr_fire;
   logic                          req_fire;
   logic                          out_free;
   logic                          div_start;
   logic                          filt_load;
   logic                          integ_load;
   logic                          mac_start;
   logic                          rsp_load;
   logic                          integ_ok;

   logic signed [COUNT_BITS:0]    count_sum;
   logic signed [XW-1:0]          x_val;
   logic [XW-1:0]                 x_mag;
   logic signed [MW-1:0]          step_mag;
   logic [XW-1:0]                 quo;
   logic [XW-1:0]                 q_clip;
   logic signed [FILT_BITS-1:0]   filt_new;
   logic signed [IW-1:0]          integ_sum;
   logic signed [IW-1:0]          integ_clamped;
   logic signed [DRIVE_BITS-1:0]  mac_drive;

   unit_stat_type                 div_stat;
   unit_stat_type                 mac_stat;

   assign csr_ready = 1'b1;
   assign csr_fire  = csr_valid & csr_ready;
   assign req_fire  = req_valid & req_ready;
   assign out_free  = ~rsp_valid_ff | rsp_ready;

   // Configuration registers.
   always_comb begin
      prop_gain_in     = prop_gain_ff;
      integ_gain_in    = integ_gain_ff;
      avoid_mode_in    = avoid_mode_ff;
      speed_divisor_in = speed_divisor_ff;
      if (csr_fire) begin
         case (csr_index)
            REG_PROP_GAIN:     prop_gain_in     = csr_data[GAIN_BITS-1:0];
            REG_INTEG_GAIN:    integ_gain_in    = csr_data[GAIN_BITS-1:0];
            REG_AVOID_MODE:    avoid_mode_in    = csr_data[0];
            REG_SPEED_DIVISOR: speed_divisor_in = csr_data[DIV_BITS-1:0];
            default: ;
         endcase
      end
   end

   // Step size: divisor 0 acts as 1; the slow target applies only at
   // divisor 1 with avoidance on. Divisor 2 halves 110 exactly to 55.
   always_comb begin
      case (speed_divisor_ff)
         2'd2:    step_mag = MOVE_SLOW;
         2'd3:    step_mag = MOVE_THIRD;
         default: step_mag = (avoid_mode_ff && (speed_divisor_ff == 2'd1)) ?
                             MOVE_SLOW : MOVE_FAST;
      endcase
   end

   // Filter dividend 4*filt + (sum << F), split into sign and magnitude
   // for the unsigned serial divider.
   always_comb begin
      count_sum = (COUNT_BITS+1)'(req_left_count) + (COUNT_BITS+1)'(req_right_count);
      x_val     = (XW'(filt_ff) <<< 2) + (XW'(count_sum) <<< FRACTION_BITS);
      x_mag     = x_val[XW-1] ? $unsigned(-x_val) : $unsigned(x_val);
   end

   // Quotient back to signed, saturated to the 26-bit filter range.
   always_comb begin
      if (neg_ff) begin
         q_clip = (quo > FILT_MIN_MAG) ? FILT_MIN_MAG : quo;
      end else begin
         q_clip = (quo > FILT_MAX_MAG) ? FILT_MAX_MAG : quo;
      end
      filt_new = neg_ff ? -FILT_BITS'(q_clip) : FILT_BITS'(q_clip);
   end

   // Integral update: the two clamps collapse into one interval.
   always_comb begin
      integ_sum = IW'(integ_ff) + IW'(filt_ff) - IW'(move_ff);
      if (integ_sum > INTEG_HI) begin
         integ_clamped = INTEG_HI;
      end else if (integ_sum < INTEG_LO) begin
         integ_clamped = INTEG_LO;
      end else begin
         integ_clamped = integ_sum;
      end
   end

   // Sequencer: next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE:   if (req_fire) state_in = ST_DIVIDE;
         ST_DIVIDE: if (div_stat.done) state_in = ST_INTEG;
         ST_INTEG:  state_in = ST_LAUNCH;
         ST_LAUNCH: state_in = ST_MAC;
         ST_MAC:    if (mac_stat.done && out_free) state_in = ST_IDLE;
         default:   state_in = ST_IDLE;
      endcase
   end

   // Sequencer: strobes.
   always_comb begin
      req_ready  = 1'b0;
      filt_load  = 1'b0;
      integ_load = 1'b0;
      mac_start  = 1'b0;
      rsp_load   = 1'b0;
      case (state_ff)
         ST_IDLE:   req_ready  = 1'b1;
         ST_DIVIDE: filt_load  = div_stat.done;
         ST_INTEG:  integ_load = 1'b1;
         ST_LAUNCH: mac_start  = 1'b1;
         ST_MAC:    rsp_load   = mac_stat.done & out_free;
         default: ;
      endcase
   end

   assign div_start = req_fire;

   // Datapath next values.
   always_comb begin
      filt_in      = filt_load  ? filt_new : filt_ff;
      integ_in     = integ_load ? INTEG_BITS'(integ_clamped) : integ_ff;
      neg_in       = req_fire   ? x_val[XW-1] : neg_ff;
      move_in      = move_ff;
      if (req_fire) begin
         // forward wins over backward; forward drives the integral up
         if (req_forward) begin
            move_in = -step_mag;
         end else if (req_backward) begin
            move_in = step_mag;
         end else begin
            move_in = '0;
         end
      end
      rsp_valid_in = rsp_load | (rsp_valid_ff & ~rsp_ready);
      rsp_drive_in = rsp_load ? mac_drive : rsp_drive_ff;
   end

   // ---------------------------------------------------------------------
   // Units
   // ---------------------------------------------------------------------
   fspl_div5 #(
      .FRACTION_BITS (FRACTION_BITS)
   ) u_div5 (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (x_mag),
      .quotient (quo),
      .stat     (div_stat)
   );

   fspl_mac #(
      .FRACTION_BITS (FRACTION_BITS)
   ) u_mac (
      .clock      (clock),
      .reset      (reset),
      .start      (mac_start),
      .filt       (filt_ff),
      .integ      (integ_ff),
      .prop_gain  (prop_gain_ff),
      .integ_gain (integ_gain_ff),
      .stat       (mac_stat),
      .drive      (mac_drive)
   );

   // ---------------------------------------------------------------------
   // Flops
   // ---------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         prop_gain_ff     <= PROP_GAIN_RST;
         integ_gain_ff    <= INTEG_GAIN_RST;
         avoid_mode_ff    <= 1'b0;
         speed_divisor_ff <= SPEED_DIV_RST;
         state_ff         <= ST_IDLE;
         filt_ff          <= '0;
         integ_ff         <= '0;
         rsp_valid_ff     <= 1'b0;
      end else begin
         prop_gain_ff     <= prop_gain_in;
         integ_gain_ff    <= integ_gain_in;
         avoid_mode_ff    <= avoid_mode_in;
         speed_divisor_ff <= speed_divisor_in;
         state_ff         <= state_in;
         filt_ff          <= filt_in;
         integ_ff         <= integ_in;
         rsp_valid_ff     <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      move_ff      <= move_in;
      neg_ff       <= neg_in;
      rsp_drive_ff <= rsp_drive_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_drive = rsp_drive_ff;

   // ---------------------------------------------------------------------
   // Assertions
   // ---------------------------------------------------------------------
   assign integ_ok = (IW'(integ_ff) <= INTEG_HI) && (IW'(integ_ff) >= INTEG_LO);

   `FSPL_ASSERT_NEXT(a_div_starts, clock, reset, req_fire, div_stat.busy, "divider not started")
   `FSPL_ASSERT_IMPL(a_one_unit, clock, reset, div_stat.busy, !mac_stat.busy, "both units busy")
   `FSPL_ASSERT_IMPL(a_integ_range, clock, reset, 1'b1, integ_ok, "integral outside clamp")
   `FSPL_ASSERT_NEXT(a_rsp_load, clock, reset, rsp_load, rsp_valid && req_ready, "handoff lost")

endmodule

>>> dv/tb_filtered_speed_pi_loop_top.sv
`timescale 1ns / 1ps

// Speed PI loop testbench.
//  - Ticks go into tick_queue from the main initial block.
//  - req_driver presents them on the req channel with random gaps.
//  - On each accepted req beat, the expected drive term is computed
//    from a local copy of the filter/integral state and the shadowed
//    gain registers.
//  - rsp_monitor stalls at random and checks each rsp beat, in order,
//    against drive_expect.
//  - CSR writes go through csr_pending and are only issued while the
//    loop is idle.
module tb_filtered_speed_pi_loop_top;
   import fspl_pkg::*;

   localparam int  FB        = FRACTION_BITS_DEF;
   localparam longint ONE    = longint'(1) << FB;
   localparam longint FILT_HI  = (longint'(1) << (FILT_BITS - 1)) - 1;
   localparam longint INTEG_HI = (longint'(1) << (INTEG_BITS - 1)) - 1;
   localparam longint I_LIMIT  = longint'(INTEGRAL_LIMIT_DEF) * ONE;
   localparam int  RSP_LATENCY = 50;

   typedef struct {
      logic signed [COUNT_BITS-1:0] left;
      logic signed [COUNT_BITS-1:0] right;
      logic                         fwd;
      logic                         bwd;
   } enc_tick_type;

   typedef struct {
      csr_reg_type              idx;
      logic [CSR_DATA_BITS-1:0] data;
   } csr_write_type;

   typedef struct {
      logic [GAIN_BITS-1:0] kp;
      logic [GAIN_BITS-1:0] ki;
      logic                 avoid;
      logic [DIV_BITS-1:0]  div;
   } loop_setting_type;

   // DUT ports; every input starts at a known value
   logic                           clock = 1'b0;
   logic                           reset = 1'b1;
   logic                           csr_valid = 1'b0;
   logic                           csr_ready;
   logic [CSR_INDEX_BITS-1:0]      csr_index = '0;
   logic [CSR_DATA_BITS-1:0]       csr_data = '0;
   logic                           req_valid = 1'b0;
   logic                           req_ready;
   logic signed [COUNT_BITS-1:0]   req_left_count = '0;
   logic signed [COUNT_BITS-1:0]   req_right_count = '0;
   logic                           req_forward = 1'b0;
   logic                           req_backward = 1'b0;
   logic                           rsp_valid;
   logic                           rsp_ready = 1'b0;
   logic signed [DRIVE_BITS-1:0]   rsp_drive;

   // stimulus and expectation stores
   enc_tick_type                   tick_queue[$];
   csr_write_type                  csr_pending[$];
   logic signed [DRIVE_BITS-1:0]   drive_expect[$];

   // shadow of the gain/command registers (reset values)
   logic [GAIN_BITS-1:0]           kp_shadow    = PROP_GAIN_RST;
   logic [GAIN_BITS-1:0]           ki_shadow    = INTEG_GAIN_RST;
   logic                           avoid_shadow = 1'b0;
   logic [DIV_BITS-1:0]            div_shadow   = SPEED_DIV_RST;

   // predicted loop state, Q(F)
   longint                         filt_est  = 0;
   longint                         integ_est = 0;

   int                             fail_count = 0;
   bit                             req_idle_on = 1'b1;
   bit                             rsp_idle_on = 1'b1;
   int                             req_gap = 0;
   int                             rsp_stall = 0;
   enc_tick_type                   req_item;

   filtered_speed_pi_loop_top u_dut (
      .clock           (clock),
      .reset           (reset),
      .csr_valid       (csr_valid),
      .csr_ready       (csr_ready),
      .csr_index       (csr_index),
      .csr_data        (csr_data),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_left_count  (req_left_count),
      .req_right_count (req_right_count),
      .req_forward     (req_forward),
      .req_backward    (req_backward),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_drive       (rsp_drive)
   );

   initial begin
      forever #6 clock = ~clock;
   end

   // hard stop; the slowest legal run is about 3 ms
   initial begin
      #12ms;
      $display("filtered_speed_pi_loop_top: mismatch");
      $finish;
   end

   function automatic longint clip(longint v, longint lo, longint hi);
      if (v > hi) return hi;
      if (v < lo) return lo;
      return v;
   endfunction

   // Gap length: mostly none or short, now and then long.
   function automatic int pick_gap(bit on);
      int r;
      if (!on) return 0;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 85) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 12);
      return $urandom_range(20, 50);
   endfunction

   // Advance the loop state by one tick and return the drive term.
   function automatic logic signed [DRIVE_BITS-1:0] predict_drive(enc_tick_type t);
      longint sum;
      longint divisor;
      longint target;
      longint step;
      longint movement;
      longint acc;
      sum      = longint'(t.left) + longint'(t.right);
      divisor  = (div_shadow == 2'd0) ? 1 : longint'(div_shadow);
      // slow target only with avoidance on and the raw divisor at one
      target   = (avoid_shadow && div_shadow == 2'd1) ? TARGET_SLOW : TARGET_FAST;
      step     = (target * ONE) / divisor;
      movement = t.fwd ? -step : (t.bwd ? step : 0);
      // 0.8 old + 0.2 new == (4*old + new) / 5, truncated toward zero
      filt_est = clip((4 * filt_est + sum * ONE) / FILTER_DIVISOR, -FILT_HI - 1, FILT_HI);
      acc      = clip(integ_est + filt_est - movement, -I_LIMIT, I_LIMIT);
      integ_est = clip(acc, -INTEG_HI - 1, INTEG_HI);
      acc = filt_est * longint'(kp_shadow) + integ_est * longint'(ki_shadow);
      acc = clip(acc / (ONE * ONE), -32768, 32767);
      return acc[DRIVE_BITS-1:0];
   endfunction

   task automatic add_tick(int left, int right, bit fwd, bit bwd);
      enc_tick_type t;
      t.left  = left[COUNT_BITS-1:0];
      t.right = right[COUNT_BITS-1:0];
      t.fwd   = fwd;
      t.bwd   = bwd;
      tick_queue.push_back(t);
   endtask

   // Random ticks in runs: mostly small counts under one held command
   // (so the integral walks into its clamps), plus heavy same-sign
   // bursts and full-range noise.
   task automatic queue_random_ticks(int count);
      int n;
      int run_len;
      int kind;
      int cmd;
      int sgn;
      int span;
      int k;
      n = 0;
      while (n < count) begin
         run_len = $urandom_range(1, 40);
         kind    = $urandom_range(0, 9);
         cmd     = $urandom_range(0, 3);
         sgn     = $urandom_range(0, 1) ? 1 : -1;
         span    = $urandom_range(0, 1) ? 40 : 300;
         for (k = 0; k < run_len && n < count; k++) begin
            if (kind == 0) begin
               add_tick($urandom, $urandom, 1'($urandom_range(0, 1)),
                        1'($urandom_range(0, 1)));
            end else if (kind == 1) begin
               add_tick(sgn * int'($urandom_range(20000, 32767)),
                        sgn * int'($urandom_range(20000, 32767)), cmd[1], cmd[0]);
            end else begin
               add_tick(int'($urandom_range(0, 2 * span)) - span,
                        int'($urandom_range(0, 2 * span)) - span, cmd[1], cmd[0]);
            end
            n++;
         end
      end
   endtask

   task automatic queue_setting(loop_setting_type s);
      csr_write_type w;
      w.idx = REG_PROP_GAIN;     w.data = s.kp;                           csr_pending.push_back(w);
      w.idx = REG_INTEG_GAIN;    w.data = s.ki;                           csr_pending.push_back(w);
      // upper bits are don't-care for the narrow registers
      w.idx = REG_AVOID_MODE;    w.data = {15'($urandom_range(0, 32767)), s.avoid};
      csr_pending.push_back(w);
      w.idx = REG_SPEED_DIVISOR; w.data = {14'($urandom_range(0, 16383)), s.div};
      csr_pending.push_back(w);
   endtask

   // Block until every queued beat has gone through and been checked.
   task automatic wait_drained();
      while (tick_queue.size() != 0 || req_valid || drive_expect.size() != 0 ||
             csr_pending.size() != 0 || csr_valid)
         @(posedge clock);
   endtask

   // CSR write channel
   always @(posedge clock) begin : csr_driver
      csr_write_type w;
      if (reset) begin
         csr_valid <= 1'b0;
      end else begin
         if (csr_valid && csr_ready) begin
            case (csr_reg_type'(csr_index))
               REG_PROP_GAIN:     kp_shadow    = csr_data;
               REG_INTEG_GAIN:    ki_shadow    = csr_data;
               REG_AVOID_MODE:    avoid_shadow = csr_data[0];
               REG_SPEED_DIVISOR: div_shadow   = csr_data[DIV_BITS-1:0];
               default: ;
            endcase
         end
         if (csr_valid && !csr_ready) begin
            // hold the write until taken
         end else if (csr_pending.size() != 0) begin
            w = csr_pending.pop_front();
            csr_valid <= 1'b1;
            csr_index <= w.idx;
            csr_data  <= w.data;
         end else begin
            csr_valid <= 1'b0;
         end
      end
   end

   // req channel driver; predicts on acceptance
   always @(posedge clock) begin : req_driver
      if (reset) begin
         req_valid <= 1'b0;
         req_gap = 0;
      end else begin
         if (req_valid && req_ready)
            drive_expect.push_back(predict_drive(req_item));
         if (req_valid && !req_ready) begin
            // beat still pending: hold valid and payload
         end else if (req_gap > 0) begin
            req_gap--;
            req_valid <= 1'b0;
         end else if (tick_queue.size() != 0) begin
            req_item = tick_queue.pop_front();
            req_left_count  <= req_item.left;
            req_right_count <= req_item.right;
            req_forward     <= req_item.fwd;
            req_backward    <= req_item.bwd;
            req_valid       <= 1'b1;
            req_gap = pick_gap(req_idle_on);
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // rsp channel monitor with random backpressure
   always @(posedge clock) begin : rsp_monitor
      logic signed [DRIVE_BITS-1:0] exp_drive;
      if (reset) begin
         rsp_ready <= 1'b0;
         rsp_stall = 0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (drive_expect.size() == 0) begin
               fail_count++;
               if (fail_count <= 10)
                  $display("%0t: rsp beat with nothing expected, drive=%0d",
                           $realtime, rsp_drive);
            end else begin
               exp_drive = drive_expect.pop_front();
               if (rsp_drive !== exp_drive) begin
                  fail_count++;
                  if (fail_count <= 10)
                     $display("%0t: drive expected %0d, got %0d",
                              $realtime, exp_drive, rsp_drive);
               end
            end
            rsp_stall = pick_gap(rsp_idle_on);
         end else if (rsp_stall == 0 && rsp_idle_on && $urandom_range(0, 15) == 0) begin
            rsp_stall = pick_gap(1'b1);
         end
         if (rsp_stall > 0) begin
            rsp_stall--;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   // main sequence
   initial begin
      loop_setting_type settings[7];
      int p;
      // divisor 0 and 3 are outside the normal range but legal field values
      settings = '{
         '{16'd0,     16'd0,     1'b0, 2'd1},
         '{16'd65535, 16'd65535, 1'b1, 2'd1},   // slow target
         '{16'd30720, 16'd102,   1'b1, 2'd2},   // avoidance ignored at div 2
         '{16'd256,   16'd4096,  1'b0, 2'd0},   // divisor zero acts as one
         '{16'd12345, 16'd777,   1'b1, 2'd3},   // divide by three
         '{16'd65535, 16'd0,     1'b0, 2'd3},
         '{16'd1,     16'd65535, 1'b1, 2'd0}
      };

      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed ticks at reset settings
      add_tick(0, 0, 0, 0);
      add_tick(32767, 32767, 0, 0);
      add_tick(-32768, -32768, 0, 0);
      add_tick(32767, -32768, 0, 0);
      add_tick(-32768, 32767, 0, 0);
      add_tick('h5555, 'hAAAA, 0, 0);
      add_tick('hAAAA, 'h5555, 1, 1);       // forward wins over backward
      add_tick(0, 0, 1, 0);
      add_tick(0, 0, 0, 1);
      add_tick(1, -1, 1, 1);
      // drive integral into the positive clamp, then the negative one
      repeat (4) add_tick(32767, 32767, 1, 0);
      repeat (6) add_tick(-32768, -32768, 0, 1);
      // let the filter decay under each command
      add_tick(0, 0, 1, 0);
      add_tick(0, 0, 0, 1);
      add_tick(0, 0, 0, 0);
      add_tick(-1, 0, 0, 0);
      queue_random_ticks(160);
      wait_drained();

      for (p = 0; p < 7; p++) begin
         req_idle_on = (p % 3 != 1);
         rsp_idle_on = (p % 3 != 2);
         queue_setting(settings[p]);
         wait_drained();
         queue_random_ticks(160);
         wait_drained();
      end

      repeat (2 * RSP_LATENCY) @(posedge clock);
      if (fail_count == 0 && drive_expect.size() == 0)
         $display("filtered_speed_pi_loop_top: match");
      else
         $display("filtered_speed_pi_loop_top: mismatch");
      $finish;
   end

endmodule
